@@ rtl/mst_tour_approximation_macros.svh @@
// Assertion macros shared by the checker of the tour approximation block.
// Depends on nothing; included by the assertion file.
`ifndef MST_TOUR_APPROXIMATION_MACROS_SVH
`define MST_TOUR_APPROXIMATION_MACROS_SVH

// Clocked property, masked while reset is held low.
`define MTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Implication that holds in the cycle after the trigger.
`define MTA_ASSERT_NEXT(lbl, trig, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

@@ rtl/mta_pkg.sv @@
// Types and constants of the tour approximation block.
// Used by the top level; depends on nothing.
package mta_pkg;
    localparam int MAX_CITIES = 16;
    localparam int CITY_BITS  = 4;
    localparam int COUNT_BITS = 5;
    localparam int COST_BITS  = 15;
    localparam int TOTAL_BITS = 19;
    localparam int SUM_BITS   = 20;
    localparam int DATA_BITS  = 24;
    localparam int ADDR_BITS  = 3;

    localparam logic [COST_BITS-1:0]  KEY_INF        = '1;
    localparam logic [ADDR_BITS-1:0]  REG_CITY_COUNT = 3'd0;
    localparam logic [COUNT_BITS-1:0] CITIES_MIN     = 5'd2;
    localparam logic [COUNT_BITS-1:0] CITIES_MAX     = 5'd16;

    typedef logic [CITY_BITS-1:0]  t_city;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [COST_BITS-1:0]  t_cost;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PICK,
        S_SET,
        S_UPD_RD,
        S_UPD,
        S_WALK_POP,
        S_WALK_CH,
        S_TOT_RD,
        S_TOT_ADD,
        S_EMIT
    } t_state;
endpackage

@@ rtl/mst_tour_approximation.sv @@
// Top level of the tour approximation block: matrix load, Prim tree, preorder walk, tour cost.
// Depends on mta_pkg and mta_ram.
//
// Channel   Dir  Handshake             Payload
// s (entry) in   i_s_tvalid/o_s_tready i_s_tdata, i_s_tlast
// m (city)  out  o_m_tvalid/i_m_tready o_m_tdata, o_m_tlast
// apb       in   psel/penable/pready   paddr, pwdata, prdata
//
// An entry without tlast leaves the block ready for the next entry. The entry with
// tlast starts the tour: the tree is built first (one cost memory read per pair),
// then the tree is walked in preorder and the tour cost summed before the cities are sent.
// Reset is synchronous and active low; it sets city_count to 16.
// A stalled result holds the output register; new entries wait until the last
// city has been loaded into it.
module mst_tour_approximation (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // from_city[3:0], to_city[7:4], edge_cost[22:8], zero
    input  logic        i_s_tlast,   // last_entry
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // tour_city[3:0], tour_total[22:4], zero
    output logic        o_m_tlast,   // last_result
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mta_pkg::*;

    t_state                r_state, n_state;
    t_count                r_city_count;
    t_cost                 r_key [MAX_CITIES];
    t_cost                 n_key [MAX_CITIES];
    logic [MAX_CITIES-1:0] r_in_tree, n_in_tree;
    t_city                 r_parent [MAX_CITIES];
    t_city                 n_parent [MAX_CITIES];
    t_city                 r_stack [MAX_CITIES];
    t_city                 n_stack [MAX_CITIES];
    t_city                 r_tour [MAX_CITIES];
    t_city                 n_tour [MAX_CITIES];
    t_count                r_depth, n_depth;
    t_count                r_count, n_count;
    t_count                r_k, n_k;
    t_city                 r_v, n_v;
    t_city                 r_round, n_round;
    t_cost                 r_best, n_best;
    t_city                 r_pick, n_pick;
    logic                  r_found, n_found;
    t_city                 r_first, n_first;
    logic                  r_ffound, n_ffound;
    t_city                 r_u, n_u;
    t_city                 r_node, n_node;
    t_city                 r_prev, n_prev;
    logic                  r_closing, n_closing;
    logic                  r_diag, n_diag;
    logic [SUM_BITS-1:0]   r_total, n_total;
    logic                  r_m_valid, n_m_valid;
    t_city                 r_m_city, n_m_city;
    logic [TOTAL_BITS-1:0] r_m_total, n_m_total;
    logic                  r_m_last, n_m_last;

    t_count                n_used;
    logic                  s_acc;
    logic [7:0]            ram_raddr;
    t_cost                 ram_rdata;
    t_cost                 cost_c;
    t_city                 city_a, city_b;
    logic                  last_v;

    assign s_acc = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_city_count < CITIES_MIN) begin
            n_used = CITIES_MIN;
        end else if (r_city_count > CITIES_MAX) begin
            n_used = CITIES_MAX;
        end else begin
            n_used = r_city_count;
        end
    end

    assign last_v = ({1'b0, r_v} == (n_used - 5'd1));

    always_comb begin
        if (r_state == S_TOT_RD && r_k >= r_count) begin
            city_a = '0;
            city_b = r_prev;
        end else if (r_state == S_TOT_RD) begin
            city_a = r_prev;
            city_b = r_tour[r_k[CITY_BITS-1:0]];
        end else begin
            city_a = r_u;
            city_b = r_v;
        end
    end

    assign ram_raddr = {city_a, city_b};

    mta_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (MAX_CITIES * MAX_CITIES)
    ) u_cost_ram (
        .i_clk   (i_clk),
        .i_we    (s_acc),
        .i_waddr ({i_s_tdata[3:0], i_s_tdata[7:4]}),
        .i_wdata (i_s_tdata[22:8]),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cost_c = r_diag ? '0 : ram_rdata;

    always_comb begin
        n_state   = r_state;
        n_key     = r_key;
        n_in_tree = r_in_tree;
        n_parent  = r_parent;
        n_stack   = r_stack;
        n_tour    = r_tour;
        n_depth   = r_depth;
        n_count   = r_count;
        n_k       = r_k;
        n_v       = r_v;
        n_round   = r_round;
        n_best    = r_best;
        n_pick    = r_pick;
        n_found   = r_found;
        n_first   = r_first;
        n_ffound  = r_ffound;
        n_u       = r_u;
        n_node    = r_node;
        n_prev    = r_prev;
        n_closing = r_closing;
        n_diag    = (city_a == city_b);
        n_total   = r_total;
        n_m_valid = r_m_valid && !i_m_tready;
        n_m_city  = r_m_city;
        n_m_total = r_m_total;
        n_m_last  = r_m_last;

        case (r_state)
            S_IDLE: begin
                if (s_acc && i_s_tlast) begin
                    for (int i = 0; i < MAX_CITIES; i++) begin
                        n_key[i]    = KEY_INF;
                        n_parent[i] = '0;
                    end
                    n_key[0]  = '0;
                    n_in_tree = '0;
                    n_round   = '0;
                    n_v       = '0;
                    n_best    = KEY_INF;
                    n_found   = 1'b0;
                    n_ffound  = 1'b0;
                    n_state   = S_PICK;
                end
            end
            S_PICK: begin
                if (!r_in_tree[r_v]) begin
                    if (r_key[r_v] < r_best) begin
                        n_best  = r_key[r_v];
                        n_pick  = r_v;
                        n_found = 1'b1;
                    end
                    if (!r_ffound) begin
                        n_first  = r_v;
                        n_ffound = 1'b1;
                    end
                end
                if (last_v) begin
                    n_state = S_SET;
                end else begin
                    n_v = r_v + 4'd1;
                end
            end
            S_SET: begin
                n_u = r_found ? r_pick : r_first;
                n_in_tree[n_u] = 1'b1;
                n_v     = '0;
                n_state = S_UPD_RD;
            end
            S_UPD_RD: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                if (cost_c != '0 && !r_in_tree[r_v] && cost_c < r_key[r_v]) begin
                    n_parent[r_v] = r_u;
                    n_key[r_v]    = cost_c;
                end
                if (last_v) begin
                    n_round = r_round + 4'd1;
                    if (({1'b0, r_round} + 5'd2) < n_used) begin
                        n_v      = '0;
                        n_best   = KEY_INF;
                        n_found  = 1'b0;
                        n_ffound = 1'b0;
                        n_state  = S_PICK;
                    end else begin
                        n_stack[0] = '0;
                        n_depth    = 5'd1;
                        n_count    = '0;
                        n_state    = S_WALK_POP;
                    end
                end else begin
                    n_v     = r_v + 4'd1;
                    n_state = S_UPD_RD;
                end
            end
            S_WALK_POP: begin
                if (r_depth != '0 && r_count < n_used) begin
                    n_node  = r_stack[4'(r_depth - 5'd1)];
                    n_depth = r_depth - 5'd1;
                    n_tour[r_count[CITY_BITS-1:0]] = n_node;
                    n_count = r_count + 5'd1;
                    n_v     = 4'(n_used - 5'd1);
                    n_state = S_WALK_CH;
                end else begin
                    n_prev  = r_tour[0];
                    n_k     = 5'd1;
                    n_total = '0;
                    n_state = S_TOT_RD;
                end
            end
            S_WALK_CH: begin
                if (r_parent[r_v] == r_node && r_depth < CITIES_MAX) begin
                    n_stack[r_depth[CITY_BITS-1:0]] = r_v;
                    n_depth = r_depth + 5'd1;
                end
                if (r_v == 4'd1) begin
                    n_state = S_WALK_POP;
                end else begin
                    n_v = r_v - 4'd1;
                end
            end
            S_TOT_RD: begin
                n_closing = (r_k >= r_count);
                n_state   = S_TOT_ADD;
            end
            S_TOT_ADD: begin
                n_total = r_total + SUM_BITS'(cost_c);
                if (r_closing) begin
                    n_k     = '0;
                    n_state = S_EMIT;
                end else begin
                    n_prev  = r_tour[r_k[CITY_BITS-1:0]];
                    n_k     = r_k + 5'd1;
                    n_state = S_TOT_RD;
                end
            end
            S_EMIT: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_city  = r_tour[r_k[CITY_BITS-1:0]];
                    n_m_last  = ((r_k + 5'd1) == r_count);
                    n_m_total = n_m_last ? r_total[TOTAL_BITS-1:0] : '0;
                    if (n_m_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 5'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_city_count <= CITIES_MAX;
            r_m_valid    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
            if (psel && penable && pwrite && pready && paddr == REG_CITY_COUNT) begin
                r_city_count <= pwdata[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_in_tree <= n_in_tree;
        r_parent  <= n_parent;
        r_stack   <= n_stack;
        r_tour    <= n_tour;
        r_depth   <= n_depth;
        r_count   <= n_count;
        r_k       <= n_k;
        r_v       <= n_v;
        r_round   <= n_round;
        r_best    <= n_best;
        r_pick    <= n_pick;
        r_found   <= n_found;
        r_first   <= n_first;
        r_ffound  <= n_ffound;
        r_u       <= n_u;
        r_node    <= n_node;
        r_prev    <= n_prev;
        r_closing <= n_closing;
        r_diag    <= n_diag;
        r_total   <= n_total;
        r_m_city  <= n_m_city;
        r_m_total <= n_m_total;
        r_m_last  <= n_m_last;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_total, r_m_city};
    assign o_m_tlast  = r_m_last;
    assign pready     = 1'b1;
    assign prdata     = (paddr == REG_CITY_COUNT) ? {27'd0, r_city_count} : 32'd0;
endmodule

@@ rtl/mta_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module mta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/mta_checker.sv @@
// Port-level checks for the tour approximation block, bound to its top level.
// Depends on mst_tour_approximation_macros.svh.
`include "mst_tour_approximation_macros.svh"

module mta_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        i_s_tlast,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tlast
);
    `MTA_ASSERT_NEXT(a_busy_after_last, i_s_tvalid && o_s_tready && i_s_tlast, !o_s_tready, "block still ready after the closing request")
    `MTA_ASSERT_NEXT(a_ready_after_entry, i_s_tvalid && o_s_tready && !i_s_tlast, o_s_tready, "block not ready after a plain entry")
    `MTA_ASSERT(a_total_only_last, (o_m_tvalid && !o_m_tlast) |-> (o_m_tdata[22:4] == 19'd0), "tour cost shown before the final city")
    `MTA_ASSERT_NEXT(a_stall_holds, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && o_m_tvalid, "stalled result changed")
endmodule

bind mst_tour_approximation mta_checker u_mta_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
